/* rtl/lcd_pkg.sv */
// Shared types and constants of the LRU cache directory.
// No dependencies; every other file imports this package.

package lcd_pkg;

   localparam int KEY_W      = 32;
   localparam int KIND_W     = 2;
   localparam int SLOT_W     = 4;
   localparam int CAP_W      = 5;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 5;

   localparam logic [CAP_W-1:0] CAP_RESET = 5'd10;

   typedef enum logic [KIND_W-1:0] {
      KIND_LOOKUP  = 2'd0,
      KIND_EVICT   = 2'd1,
      KIND_INSERT  = 2'd2,
      KIND_IGNORED = 2'd3
   } kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CAPACITY = 1'b0,
      CSR_ENABLE   = 1'b1
   } csr_reg_type;

   // controller -> datapath
   typedef struct packed {
      logic req_take;    // request transfer this cycle
      logic scan_clear;  // start of a directory scan
      logic rd_issue;    // key memory read at rd_addr
      logic evict;       // emit eviction notice and drop the victim
      logic finish;      // emit final result and commit the update
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic enable;
      logic req_type;
      logic match_found;
      logic need_evict;
      logic scan_last;
      logic out_free;
   } status_type;

endpackage

/* rtl/lcd_req_if.sv */
// Request channel: valid/ready handshake carrying request type and key.
// Depends on lcd_pkg.

interface lcd_req_if import lcd_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic                    req_type;
   logic signed [KEY_W-1:0] key;

   modport source (output valid, output req_type, output key, input ready);
   modport sink   (input valid, input req_type, input key, output ready);
endinterface

/* rtl/lcd_rsp_if.sv */
// Result channel: valid/ready handshake carrying one directory result.
// Depends on lcd_pkg.

interface lcd_rsp_if import lcd_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [KIND_W-1:0]       kind;
   logic                    hit;
   logic [SLOT_W-1:0]       slot;
   logic signed [KEY_W-1:0] evicted_key;
   logic                    last;

   modport source (output valid, output kind, output hit, output slot,
                   output evicted_key, output last, input ready);
   modport sink   (input valid, input kind, input hit, input slot,
                   input evicted_key, input last, output ready);
endinterface

/* rtl/lcd_ctrl.sv */
// Sequencer of the LRU cache directory: request intake, scan counter,
// eviction loop and result issue. Depends on lcd_pkg.

module lcd_ctrl import lcd_pkg::*; #(
   parameter int MAX_ENTRIES = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  status_type                     status,
   output cmd_type                        cmd,
   output logic [$clog2(MAX_ENTRIES)-1:0] rd_addr
);

   localparam int SW    = $clog2(MAX_ENTRIES);
   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_SCAN   = 5'b00010,
      ST_DECIDE = 5'b00100,
      ST_EVICT  = 5'b01000,
      ST_FINISH = 5'b10000
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   assign req_ready = (state_ff == ST_IDLE);
   assign rd_addr   = cnt_ff[SW-1:0];

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.req_take = 1'b1;
               if (status.enable) begin
                  cmd.scan_clear = 1'b1;
                  cnt_in         = '0;
                  state_in       = ST_SCAN;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_SCAN: begin
            if (cnt_ff < CNT_W'(MAX_ENTRIES)) begin
               cmd.rd_issue = 1'b1;
               cnt_in       = cnt_ff + 1'b1;
            end
            if (status.scan_last) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (status.req_type && !status.match_found && status.need_evict) begin
               state_in = ST_EVICT;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_EVICT: begin
            // rescan afterwards: next victim and lowest free slot
            if (status.out_free) begin
               cmd.evict      = 1'b1;
               cmd.scan_clear = 1'b1;
               cnt_in         = '0;
               state_in       = ST_SCAN;
            end
         end
         ST_FINISH: begin
            if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

/* rtl/lcd_dpath.sv */
// Datapath of the LRU cache directory: key memory, valid bits, recency
// ranks, entry count, config registers, scan records and result register.
// Depends on lcd_pkg and lcd_rsp_if.

module lcd_dpath import lcd_pkg::*; #(
   parameter int MAX_ENTRIES = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [CSR_IDX_W-1:0]           csr_index,
   input  logic [CSR_DATA_W-1:0]          csr_wdata,
   input  logic                           req_type,
   input  logic signed [KEY_W-1:0]        req_key,
   input  cmd_type                        cmd,
   input  logic [$clog2(MAX_ENTRIES)-1:0] rd_addr,
   output status_type                     status,
   lcd_rsp_if.source                      rsp_chan
);

   localparam int SW  = $clog2(MAX_ENTRIES);
   localparam int CW  = $clog2(MAX_ENTRIES + 1);
   localparam int CEW = (CW > CAP_W) ? CW : CAP_W;

   // key storage, one read port for the scan
   logic signed [KEY_W-1:0] key_mem [MAX_ENTRIES];
   logic signed [KEY_W-1:0] key_rd_ff;
   logic                    mem_we;

   logic [MAX_ENTRIES-1:0]  valid_ff, valid_in;
   logic [SW-1:0]           rank_ff [MAX_ENTRIES];
   logic [SW-1:0]           rank_in [MAX_ENTRIES];
   logic [CW-1:0]           count_ff, count_in;

   logic [CAP_W-1:0]        cap_ff, cap_in;
   logic                    en_ff, en_in;

   logic                    req_type_ff;
   logic signed [KEY_W-1:0] req_key_ff;

   logic                    rd_vld_ff;
   logic [SW-1:0]           rd_idx_ff;

   logic                    match_found_ff, match_found_in;
   logic [SW-1:0]           match_slot_ff, match_slot_in;
   logic [SW-1:0]           match_rank_ff, match_rank_in;
   logic                    free_found_ff, free_found_in;
   logic [SW-1:0]           free_slot_ff, free_slot_in;
   logic [SW-1:0]           victim_slot_ff, victim_slot_in;
   logic signed [KEY_W-1:0] victim_key_ff, victim_key_in;

   logic                    rsp_vld_ff, rsp_vld_in;
   kind_type                rsp_kind_ff, rsp_kind_in;
   logic                    rsp_hit_ff, rsp_hit_in;
   logic [SLOT_W-1:0]       rsp_slot_ff, rsp_slot_in;
   logic signed [KEY_W-1:0] rsp_ekey_ff, rsp_ekey_in;
   logic                    rsp_last_ff, rsp_last_in;

   logic                    rd_entry_valid;
   logic [SW-1:0]           rd_entry_rank;
   logic [CEW-1:0]          cap_ext;
   logic [CEW-1:0]          cap_eff;
   logic                    need_evict;

   function automatic logic [SLOT_W-1:0] to_slot(input logic [SW-1:0] idx);
      logic [SW+SLOT_W-1:0] wide;
      wide = {{SLOT_W{1'b0}}, idx};
      return wide[SLOT_W-1:0];
   endfunction

   // zero acts as one, above the directory size acts as the size
   assign cap_ext = CEW'(cap_ff);
   always_comb begin
      cap_eff = cap_ext;
      if (cap_ff == '0) begin
         cap_eff = CEW'(1);
      end else if (cap_ext > CEW'(MAX_ENTRIES)) begin
         cap_eff = CEW'(MAX_ENTRIES);
      end
   end
   assign need_evict = (count_ff != '0) && (CEW'(count_ff) >= cap_eff);

   assign rd_entry_valid = valid_ff[rd_idx_ff];
   assign rd_entry_rank  = rank_ff[rd_idx_ff];

   assign status.enable      = en_ff;
   assign status.req_type    = req_type_ff;
   assign status.match_found = match_found_ff;
   assign status.need_evict  = need_evict;
   assign status.scan_last   = rd_vld_ff && (rd_idx_ff == SW'(MAX_ENTRIES - 1));
   assign status.out_free    = !rsp_vld_ff || rsp_chan.ready;

   assign rsp_chan.valid       = rsp_vld_ff;
   assign rsp_chan.kind        = rsp_kind_ff;
   assign rsp_chan.hit         = rsp_hit_ff;
   assign rsp_chan.slot        = rsp_slot_ff;
   assign rsp_chan.evicted_key = rsp_ekey_ff;
   assign rsp_chan.last        = rsp_last_ff;

   // config registers
   always_comb begin
      cap_in = cap_ff;
      en_in  = en_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_CAPACITY: cap_in = csr_wdata[CAP_W-1:0];
            CSR_ENABLE:   en_in  = csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   // scan records: first match, lowest free slot, least recent entry
   always_comb begin
      match_found_in = match_found_ff;
      match_slot_in  = match_slot_ff;
      match_rank_in  = match_rank_ff;
      free_found_in  = free_found_ff;
      free_slot_in   = free_slot_ff;
      victim_slot_in = victim_slot_ff;
      victim_key_in  = victim_key_ff;
      if (cmd.scan_clear) begin
         match_found_in = 1'b0;
         free_found_in  = 1'b0;
      end else if (rd_vld_ff) begin
         if (rd_entry_valid && (key_rd_ff == req_key_ff) && !match_found_ff) begin
            match_found_in = 1'b1;
            match_slot_in  = rd_idx_ff;
            match_rank_in  = rd_entry_rank;
         end
         if (!rd_entry_valid && !free_found_ff) begin
            free_found_in = 1'b1;
            free_slot_in  = rd_idx_ff;
         end
         // valid ranks are exactly 0..count-1, so the oldest is count-1
         if (rd_entry_valid && (CW'(rd_entry_rank) == count_ff - 1'b1)) begin
            victim_slot_in = rd_idx_ff;
            victim_key_in  = key_rd_ff;
         end
      end
   end

   // directory update and result register
   always_comb begin
      valid_in    = valid_ff;
      rank_in     = rank_ff;
      count_in    = count_ff;
      mem_we      = 1'b0;
      rsp_vld_in  = rsp_vld_ff && !rsp_chan.ready;
      rsp_kind_in = rsp_kind_ff;
      rsp_hit_in  = rsp_hit_ff;
      rsp_slot_in = rsp_slot_ff;
      rsp_ekey_in = rsp_ekey_ff;
      rsp_last_in = rsp_last_ff;
      if (cmd.evict) begin
         valid_in[victim_slot_ff] = 1'b0;
         rank_in[victim_slot_ff]  = '0;
         count_in                 = count_ff - 1'b1;
         rsp_vld_in               = 1'b1;
         rsp_kind_in              = KIND_EVICT;
         rsp_hit_in               = 1'b0;
         rsp_slot_in              = to_slot(victim_slot_ff);
         rsp_ekey_in              = victim_key_ff;
         rsp_last_in              = 1'b0;
      end else if (cmd.finish) begin
         rsp_vld_in  = 1'b1;
         rsp_last_in = 1'b1;
         rsp_hit_in  = 1'b0;
         rsp_slot_in = '0;
         rsp_ekey_in = '0;
         rsp_kind_in = req_type_ff ? KIND_INSERT : KIND_LOOKUP;
         if (!en_ff) begin
            rsp_kind_in = req_type_ff ? KIND_IGNORED : KIND_LOOKUP;
         end else if (match_found_ff) begin
            // promote: entries more recent than the hit age by one
            for (int i = 0; i < MAX_ENTRIES; i++) begin
               if (valid_ff[i] && (rank_ff[i] < match_rank_ff)) begin
                  rank_in[i] = rank_ff[i] + 1'b1;
               end
            end
            rank_in[match_slot_ff] = '0;
            rsp_hit_in             = 1'b1;
            rsp_slot_in            = to_slot(match_slot_ff);
         end else if (req_type_ff) begin
            for (int i = 0; i < MAX_ENTRIES; i++) begin
               if (valid_ff[i]) begin
                  rank_in[i] = rank_ff[i] + 1'b1;
               end
            end
            mem_we                 = 1'b1;
            valid_in[free_slot_ff] = 1'b1;
            rank_in[free_slot_ff]  = '0;
            count_in               = count_ff + 1'b1;
            rsp_slot_in            = to_slot(free_slot_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         key_mem[free_slot_ff] <= req_key_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_issue) begin
         key_rd_ff <= key_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= '0;
         count_ff   <= '0;
         cap_ff     <= CAP_RESET;
         en_ff      <= 1'b1;
         rd_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
         for (int i = 0; i < MAX_ENTRIES; i++) begin
            rank_ff[i] <= '0;
         end
      end else begin
         valid_ff   <= valid_in;
         count_ff   <= count_in;
         cap_ff     <= cap_in;
         en_ff      <= en_in;
         rd_vld_ff  <= cmd.rd_issue;
         rsp_vld_ff <= rsp_vld_in;
         rank_ff    <= rank_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.req_take) begin
         req_type_ff <= req_type;
         req_key_ff  <= req_key;
      end
      rd_idx_ff      <= rd_addr;
      match_found_ff <= match_found_in;
      match_slot_ff  <= match_slot_in;
      match_rank_ff  <= match_rank_in;
      free_found_ff  <= free_found_in;
      free_slot_ff   <= free_slot_in;
      victim_slot_ff <= victim_slot_in;
      victim_key_ff  <= victim_key_in;
      rsp_kind_ff    <= rsp_kind_in;
      rsp_hit_ff     <= rsp_hit_in;
      rsp_slot_ff    <= rsp_slot_in;
      rsp_ekey_ff    <= rsp_ekey_in;
      rsp_last_ff    <= rsp_last_in;
   end

endmodule

/* rtl/lru_cache_directory_unit.sv */
// Fully associative LRU directory of keys, top level. Holds up to MAX_ENTRIES
// keys with a recency rank each. A lookup transfer answers hit/miss and slot
// and makes a hit the most recent entry; an insert transfer of a new key
// first sends one eviction notice per least recent entry it drops (until
// the count is below capacity, where capacity 0 counts as 1), then one
// "insert done" result carrying the lowest free slot; an insert of a present
// key just refreshes it. Every request ends with a result that has last set.
// With cache_enable low, nothing changes and one result comes back at once.
// Timing: each enabled request scans the key memory one entry per cycle
// through its single read port, and every eviction rescans it to find the
// next victim and the lowest free slot. A finished result sits in an output
// register, so the next request is taken while it waits; further results
// stall until it has been transferred. Config writes must only be made while
// idle; the block does not enforce this. Depends on lcd_pkg, lcd_req_if,
// lcd_rsp_if, lcd_ctrl and lcd_dpath.

module lru_cache_directory_unit import lcd_pkg::*; #(
   parameter int MAX_ENTRIES = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   lcd_req_if.sink               req_chan,
   lcd_rsp_if.source             rsp_chan,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int SW = $clog2(MAX_ENTRIES);

   cmd_type       cmd;
   status_type    status;
   logic [SW-1:0] rd_addr;

   // sequencer: one request at a time, scan then evict loop then finish
   lcd_ctrl #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd),
      .rd_addr   (rd_addr)
   );

   // storage, recency bookkeeping and result register
   lcd_dpath #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_type  (req_chan.req_type),
      .req_key   (req_chan.key),
      .cmd       (cmd),
      .rd_addr   (rd_addr),
      .status    (status),
      .rsp_chan  (rsp_chan)
   );

endmodule

/* tb/lru_cache_directory_unit_tb.sv */
// Self-checking testbench of lru_cache_directory_unit: directed cases, then
// random request streams over several capacity and enable settings.
// Depends on lcd_pkg, lcd_req_if, lcd_rsp_if and the unit under test.

module lru_cache_directory_unit_tb import lcd_pkg::*; ();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_SLOTS      = 16;
   localparam int KEY_POOL_SIZE  = 24;
   localparam int WATCHDOG_LIMIT = 5000;   // cycles with no transfer at all
   localparam int HOLD_OFF_LEN   = 400;    // long receiver stall
   localparam int NUM_PHASES     = 9;

   // request type codes of the input channel
   localparam logic REQ_LOOKUP = 1'b0;
   localparam logic REQ_INSERT = 1'b1;

   // One directory result as the block should send it.
   typedef struct {
      kind_type          kind;
      logic              hit;
      logic [SLOT_W-1:0] slot;
      logic [KEY_W-1:0]  evicted_key;
      logic              last;
   } dir_result_type;

   logic clock = 1'b0;
   logic reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   lcd_req_if req_if ();
   lcd_rsp_if rsp_if ();

   lru_cache_directory_unit #(
      .MAX_ENTRIES (NUM_SLOTS)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   // ------------------------------------------------------------------
   // Shadow copy of the directory. It is advanced at every request
   // transfer, so it always reflects the state after the newest accepted
   // request; the stimulus uses it to pick hits and misses on purpose.
   // ------------------------------------------------------------------
   logic [KEY_W-1:0] shadow_key   [NUM_SLOTS];
   bit               shadow_valid [NUM_SLOTS];
   int               shadow_rank  [NUM_SLOTS];   // 0 = most recent
   int               shadow_count;
   logic [CAP_W-1:0] cfg_capacity;
   logic             cfg_enable;

   dir_result_type pending_answers[$];   // results still owed by the block

   int mismatches = 0;
   int items_sent = 0;
   int burst_left = 0;
   bit sender_gaps = 1'b1;

   // receiver control, written by the test with NBAs, read by the
   // ready process only
   logic rx_stalls  = 1'b1;
   logic hold_token = 1'b0;
   int   hold_len   = 0;

   logic [KEY_W-1:0] key_pool [KEY_POOL_SIZE];

   int idle_cycles = 0;

   function automatic void queue_answer(input kind_type kd, input logic h,
                                        input logic [SLOT_W-1:0] sl,
                                        input logic [KEY_W-1:0] ek,
                                        input logic lst);
      dir_result_type r;
      r.kind        = kd;
      r.hit         = h;
      r.slot        = sl;
      r.evicted_key = ek;
      r.last        = lst;
      pending_answers.push_back(r);
   endfunction

   function automatic int find_slot(input logic [KEY_W-1:0] k);
      for (int i = 0; i < NUM_SLOTS; i++)
         if (shadow_valid[i] && shadow_key[i] == k)
            return i;
      return -1;
   endfunction

   // Make slot s the most recent; everything newer than it ages by one.
   function automatic void promote_slot(input int s);
      int r;
      r = shadow_rank[s];
      for (int i = 0; i < NUM_SLOTS; i++)
         if (shadow_valid[i] && shadow_rank[i] < r)
            shadow_rank[i]++;
      shadow_rank[s] = 0;
   endfunction

   // Apply one request to the shadow directory and queue what it yields.
   function automatic void predict_directory(input logic rtype,
                                             input logic [KEY_W-1:0] k);
      int s;
      int victim;
      int cap_eff;
      if (!cfg_enable) begin
         // disabled: one result, state untouched
         queue_answer(rtype == REQ_INSERT ? KIND_IGNORED : KIND_LOOKUP,
                      1'b0, '0, '0, 1'b1);
         return;
      end
      s = find_slot(k);
      if (rtype == REQ_LOOKUP) begin
         if (s < 0) begin
            queue_answer(KIND_LOOKUP, 1'b0, '0, '0, 1'b1);
         end else begin
            promote_slot(s);
            queue_answer(KIND_LOOKUP, 1'b1, SLOT_W'(s), '0, 1'b1);
         end
         return;
      end
      if (s >= 0) begin
         // insert of a present key only refreshes it
         promote_slot(s);
         queue_answer(KIND_INSERT, 1'b1, SLOT_W'(s), '0, 1'b1);
         return;
      end
      cap_eff = (cfg_capacity == 0) ? 1 :
                (cfg_capacity > NUM_SLOTS) ? NUM_SLOTS : int'(cfg_capacity);
      // evict oldest entries until there is room below capacity
      while (shadow_count >= cap_eff && shadow_count > 0) begin
         victim = -1;
         for (int i = 0; i < NUM_SLOTS; i++)
            if (shadow_valid[i] &&
                (victim < 0 || shadow_rank[i] > shadow_rank[victim]))
               victim = i;
         if (victim < 0) begin
            shadow_count = 0;
            break;
         end
         shadow_valid[victim] = 1'b0;
         shadow_rank[victim]  = 0;
         shadow_count--;
         queue_answer(KIND_EVICT, 1'b0, SLOT_W'(victim), shadow_key[victim],
                      1'b0);
      end
      // lowest free slot takes the new key as most recent
      s = 0;
      for (int i = 0; i < NUM_SLOTS; i++)
         if (!shadow_valid[i]) begin
            s = i;
            break;
         end
      for (int i = 0; i < NUM_SLOTS; i++)
         if (shadow_valid[i])
            shadow_rank[i]++;
      shadow_key[s]   = k;
      shadow_valid[s] = 1'b1;
      shadow_rank[s]  = 0;
      shadow_count++;
      queue_answer(KIND_INSERT, 1'b0, SLOT_W'(s), '0, 1'b1);
   endfunction

   task automatic report_mismatch(input string what, input logic [KEY_W-1:0] got,
                                  input logic [KEY_W-1:0] want);
      $display("ERROR at %0t: %s: got %h, expected %h", $time, what, got, want);
      mismatches++;
   endtask

   // ------------------------------------------------------------------
   // Sender: one request per call. valid stays high across a burst; at the
   // end of a burst, when sender_gaps is set, it drops for a random gap, so
   // gaps land on every phase of the scan.
   // ------------------------------------------------------------------
   task automatic send_item(input logic rtype, input logic [KEY_W-1:0] k);
      int gap;
      req_if.valid    <= 1'b1;
      req_if.req_type <= rtype;
      req_if.key      <= k;
      do @(posedge clock); while (!req_if.ready);
      predict_directory(rtype, k);
      items_sent++;
      if (sender_gaps) begin
         if (burst_left > 0)
            burst_left--;
         if (burst_left == 0) begin
            gap = $urandom_range(1, 30);
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clock);
            burst_left = $urandom_range(1, 8);
         end
      end
   endtask

   // Sender pauses until the block owes nothing, then lets it settle.
   task automatic drain_results(input int settle);
      req_if.valid <= 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   // Register write; only made with the block idle.
   task automatic write_reg(input csr_reg_type idx, input logic [CSR_DATA_W-1:0] val);
      drain_results(6);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      if (idx == CSR_CAPACITY)
         cfg_capacity = val;
      else
         cfg_enable = val[0];
   endtask

   // Mostly well-formed traffic: lookup a pooled key, insert it after a miss.
   // The rest is noise: fully random keys and inserts of present keys.
   task automatic send_random_item();
      int pick;
      logic [KEY_W-1:0] k;
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
         send_item(1'($urandom_range(0, 1)), $urandom);
      end else begin
         k = key_pool[$urandom_range(0, KEY_POOL_SIZE - 1)];
         if (find_slot(k) >= 0 || !cfg_enable) begin
            send_item(pick < 75 ? REQ_LOOKUP : REQ_INSERT, k);
         end else begin
            send_item(REQ_LOOKUP, k);
            if ($urandom_range(0, 99) < 85)
               send_item(REQ_INSERT, k);
         end
      end
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Reset settings: empty directory, extreme keys, hits, refresh.
   task automatic test_basic_lookup_insert();
      send_item(REQ_LOOKUP, 32'h0000_0000);     // miss on empty
      send_item(REQ_INSERT, 32'h8000_0000);
      send_item(REQ_INSERT, 32'h7FFF_FFFF);
      send_item(REQ_INSERT, 32'h0000_0000);
      send_item(REQ_INSERT, 32'hFFFF_FFFF);
      send_item(REQ_LOOKUP, 32'h7FFF_FFFF);     // hit, becomes newest
      send_item(REQ_LOOKUP, 32'h7FFF_FFFE);     // one bit off: miss
      send_item(REQ_INSERT, 32'h8000_0000);     // present: refresh only
      send_item(REQ_LOOKUP, 32'hFFFF_FFFF);
   endtask

   // Disabled cache: present key misses, insert is ignored.
   task automatic test_cache_disabled();
      write_reg(CSR_ENABLE, 5'b11110);          // bit 0 low
      send_item(REQ_LOOKUP, 32'h7FFF_FFFF);
      send_item(REQ_INSERT, 32'h0000_0055);
      write_reg(CSR_ENABLE, 5'b00001);
      send_item(REQ_LOOKUP, 32'h7FFF_FFFF);
   endtask

   // Capacity zero counts as one: the first new key empties the directory.
   task automatic test_capacity_zero();
      write_reg(CSR_CAPACITY, 5'd0);
      send_item(REQ_INSERT, 32'h0000_0001);
      send_item(REQ_INSERT, 32'h0000_0002);
      send_item(REQ_LOOKUP, 32'h0000_0001);
   endtask

   // Random streams over a sweep of settings. Filling at capacity 31 and
   // then dropping to 1 gives the longest eviction chain; lowered capacity
   // leaves extra entries that can still hit until the next new insert.
   task automatic test_random_phases();
      int phase_cap [NUM_PHASES];
      int phase_en  [NUM_PHASES];
      int phase_len [NUM_PHASES];
      int target;
      phase_cap = '{31, 1, 16, 0, 5, 5, 12, 2, 10};
      phase_en  = '{1,  1, 1,  1, 0, 1, 1,  1, 1};
      phase_len = '{60, 30, 50, 25, 10, 40, 40, 30, 20};
      for (int p = 0; p < NUM_PHASES; p++) begin
         write_reg(CSR_CAPACITY, CSR_DATA_W'(phase_cap[p]));
         write_reg(CSR_ENABLE, {4'($urandom_range(0, 15)), 1'(phase_en[p])});
         sender_gaps = ($urandom_range(0, 3) != 0);
         rx_stalls  <= ($urandom_range(0, 3) != 0);
         target = items_sent + phase_len[p];
         while (items_sent < target)
            send_random_item();
      end
   endtask

   // Receiver holds off while the sender keeps offering: the output
   // register fills and the input stalls. Then a full pause, then more.
   task automatic test_backpressure();
      drain_results(4);
      sender_gaps = 1'b0;
      hold_len   <= HOLD_OFF_LEN;
      hold_token <= ~hold_token;
      repeat (10) send_random_item();
      drain_results(4);
      sender_gaps = 1'b1;
      rx_stalls  <= 1'b1;
      repeat (6) send_random_item();
   endtask

   // ------------------------------------------------------------------
   // Receiver: ready follows a rotating pattern, reloaded now and then,
   // or stays high; a hold-off request forces it low while a hold count loaded from hold_len runs down.
   // ------------------------------------------------------------------
   logic        hold_seen = 1'b0;
   int          hold_left = 0;
   logic [15:0] stall_pat = 16'hB6D5;
   int          pat_age   = 0;

   always @(posedge clock) begin
      if (hold_token != hold_seen) begin
         hold_seen = hold_token;
         hold_left = hold_len;
      end
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_if.ready <= 1'b0;
      end else if (!rx_stalls) begin
         rsp_if.ready <= 1'b1;
      end else begin
         stall_pat = {stall_pat[14:0], stall_pat[15]};
         pat_age++;
         if (pat_age == 48) begin
            pat_age   = 0;
            stall_pat = 16'($urandom) | 16'h0001;   // never all stalled
         end
         rsp_if.ready <= stall_pat[0];
      end
   end

   // ------------------------------------------------------------------
   // Checker: each result transfer against the oldest owed result.
   // ------------------------------------------------------------------
   always @(posedge clock) begin : check_results
      dir_result_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_answers.size() == 0) begin
            report_mismatch("result with nothing owed, kind", KEY_W'(rsp_if.kind), '0);
         end else begin
            want = pending_answers.pop_front();
            if (rsp_if.kind !== want.kind)
               report_mismatch("kind", KEY_W'(rsp_if.kind), KEY_W'(want.kind));
            if (rsp_if.hit !== want.hit)
               report_mismatch("hit", KEY_W'(rsp_if.hit), KEY_W'(want.hit));
            if (rsp_if.slot !== want.slot)
               report_mismatch("slot", KEY_W'(rsp_if.slot), KEY_W'(want.slot));
            if (rsp_if.evicted_key !== want.evicted_key)
               report_mismatch("evicted_key", rsp_if.evicted_key, want.evicted_key);
            if (rsp_if.last !== want.last)
               report_mismatch("last", KEY_W'(rsp_if.last), KEY_W'(want.last));
         end
      end
   end

   // Watchdog: too long with no transfer on either channel ends the run.
   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL lru_cache_directory_unit");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin
      reset           <= 1'b1;
      csr_we          <= 1'b0;
      csr_index       <= CSR_CAPACITY;
      csr_wdata       <= '0;
      req_if.valid    <= 1'b0;
      req_if.req_type <= REQ_LOOKUP;
      req_if.key      <= '0;

      for (int i = 0; i < NUM_SLOTS; i++) begin
         shadow_key[i]   = '0;
         shadow_valid[i] = 1'b0;
         shadow_rank[i]  = 0;
      end
      shadow_count = 0;
      cfg_capacity = CAP_RESET;
      cfg_enable   = 1'b1;

      // pool of near-duplicate pairs (one bit apart), then extremes over entries 0 and 2
      for (int i = 0; i < KEY_POOL_SIZE; i++) begin
         if (i % 2 == 1)
            key_pool[i] = key_pool[i-1] ^ (32'h1 << $urandom_range(0, 31));
         else
            key_pool[i] = $urandom;
      end
      key_pool[0] = 32'h8000_0000;
      key_pool[2] = 32'h7FFF_FFFF;
      burst_left  = $urandom_range(1, 8);

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_basic_lookup_insert();
      test_cache_disabled();
      test_capacity_zero();
      test_random_phases();
      test_backpressure();

      drain_results(40);
      if (mismatches == 0)
         $display("PASS lru_cache_directory_unit");
      else
         $display("FAIL lru_cache_directory_unit");
      $finish;
   end

endmodule

/* lru_cache_directory_unit.f */
rtl/lcd_pkg.sv
rtl/lcd_req_if.sv
rtl/lcd_rsp_if.sv
rtl/lcd_ctrl.sv
rtl/lcd_dpath.sv
rtl/lru_cache_directory_unit.sv
tb/lru_cache_directory_unit_tb.sv
